// ===== hw/rtl/rdp_pkg.sv =====
// Shared constants and register codes for the polyline simplifier.
// No dependencies; imported by rdp_mul and polyline_simplify_rdp.
package rdp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 8;
  localparam int MUL_W_DEF      = 25;

  localparam int THR_W = 12;
  localparam int SPC_W = 4;
  localparam int Q8_SHIFT = 16;

  localparam logic [THR_W-1:0] THR_RESET = 12'd243;
  localparam logic [SPC_W-1:0] SPC_RESET = 4'd3;

  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_SPACING   = 1'b1
  } cfg_reg_e;

endpackage

// ===== hw/rtl/rdp_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on rdp_pkg for the default operand width.
module rdp_mul #(
  parameter int W = rdp_pkg::MUL_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);
  import rdp_pkg::*;

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/polyline_simplify_rdp.sv =====
// Polyline simplifier top level: point store, segment stack, keep flags and sequencer.
// Depends on rdp_pkg and rdp_mul.
//
// Usage: points stream in on s_axis (x, y in tdata, tlast on the final point).
// Loading takes one cycle per point; tready stays high while loading.
// The request carrying tlast starts simplification and tready drops until the
// last result has been taken. Points beyond MAX_POINTS are dropped and flagged.
// Simplification walks segments popped from a stack through one shared multiplier:
// kept interior points are scanned, removed ones are skipped, then the distance
// test and a sweep follow. Results then leave on m_axis, one per stored point in
// order; a stall holds the result in the output register. tlast marks the final
// result of the contour. Configuration writes on cfg_* act on the next contour if
// made between contours; the user must ensure this, the block does not enforce
// it. Reset restores registers to threshold 243, spacing 3, empties the store and
// sets every keep flag; no clearing pass is needed.
module polyline_simplify_rdp #(
  parameter int MAX_POINTS = rdp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = rdp_pkg::COORD_BITS_DEF,
  localparam int IDXW = $clog2(MAX_POINTS),
  localparam int IN_W = ((2*COORD_BITS + 7) / 8) * 8,
  localparam int OUT_N = IDXW + 2*COORD_BITS + 2,
  localparam int OUT_W = ((OUT_N + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: point_x, point_y
  input  logic [IN_W-1:0]               s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tlast_i,
  output logic                          s_axis_tready_o,
  // tdata: point_index, out_x, out_y, keep, overflow
  output logic [OUT_W-1:0]              m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  output logic                          m_axis_tlast_o,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_we_i,
  input  rdp_pkg::cfg_reg_e             cfg_addr_i,
  input  logic [rdp_pkg::THR_W-1:0]     cfg_wdata_i
);
  import rdp_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int DW  = $clog2(MAX_POINTS + 1);
  localparam int CW  = 2*C + 2;
  localparam int MW  = (2*C + 3 > 25) ? 2*C + 3 : 25;

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT, ST_POP, ST_SEG, ST_RD_E, ST_ENDS, ST_SCAN, ST_PT,
    ST_M1, ST_M2, ST_CMP, ST_DECIDE, ST_CH1, ST_CH2, ST_CH3, ST_CH4, ST_CH5,
    ST_PUSH2, ST_SWEEP, ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
  } state_e;

  state_e state_q;

  // configuration
  logic [THR_W-1:0] thr_q;
  logic [SPC_W-1:0] spc_q;

  // point store
  logic [2*C-1:0]  store_mem [MAX_POINTS];
  logic [2*C-1:0]  store_rdata_q;
  logic [IDXW-1:0] store_raddr;
  logic            store_we;

  // segment stack
  logic [2*IDXW-1:0] stack_mem [MAX_POINTS];
  logic [2*IDXW-1:0] stack_rdata_q;
  logic [2*IDXW-1:0] stack_wdata;
  logic [IDXW-1:0]   stack_waddr;
  logic [IDXW-1:0]   stack_raddr;
  logic              stack_we;

  logic [MAX_POINTS-1:0] keep_q;
  logic [DW-1:0]         count_q;
  logic [DW-1:0]         depth_q;
  logic                  ovf_q;

  logic [IDXW-1:0] s_q, e_q, i_q, best_q, out_idx_q;
  logic [C-1:0]    xs_q, ys_q;
  logic signed [C:0] ex_q, ey_q, px_q, py_q;
  logic [CW-1:0]   cmax_q;
  logic signed [2*MW-1:0] prod1_q;
  logic [MW-1:0]   acc_q, chord_q;
  logic [2*MW-1:0] rhs_q;
  logic            line_q;
  logic [SPC_W-1:0] phase_q;

  logic [OUT_W-1:0] out_data_q;
  logic             out_valid_q, out_last_q;

  // shared multiplier
  logic                   mul_en;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;

  rdp_mul #(.W(MW)) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic [IDXW-1:0] seg_s, seg_e;
  logic [C-1:0]    rd_x, rd_y;
  logic signed [2*MW-1:0] cross_d, cross_abs;
  logic [CW-1:0]   cross_c;
  logic [2*MW+Q8_SHIFT-1:0] lhs, rhs_ext;
  logic [SPC_W-1:0] spacing;
  logic            i_before_last;
  logic            in_acc, out_acc;

  assign seg_s = stack_rdata_q[2*IDXW-1:IDXW];
  assign seg_e = stack_rdata_q[IDXW-1:0];
  assign rd_x  = store_rdata_q[C-1:0];
  assign rd_y  = store_rdata_q[2*C-1:C];

  assign cross_d   = prod1_q - mul_p;
  assign cross_abs = cross_d[2*MW-1] ? -cross_d : cross_d;
  assign cross_c   = cross_abs[CW-1:0];
  assign lhs       = {mul_p, {Q8_SHIFT{1'b0}}};
  assign rhs_ext   = {{Q8_SHIFT{1'b0}}, rhs_q};
  assign spacing   = (spc_q == '0) ? SPC_W'(1) : spc_q;
  assign i_before_last = ({1'b0, i_q} + (IDXW+1)'(1)) < {1'b0, e_q};

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_M1: begin
        mul_en = 1'b1;
        mul_a  = MW'(ex_q);
        mul_b  = MW'(py_q);
      end
      ST_M2: begin
        mul_en = 1'b1;
        mul_a  = MW'(ey_q);
        mul_b  = MW'(px_q);
      end
      ST_DECIDE: begin
        mul_en = 1'b1;
        mul_a  = MW'(ex_q);
        mul_b  = MW'(ex_q);
      end
      ST_CH1: begin
        mul_en = 1'b1;
        mul_a  = MW'(ey_q);
        mul_b  = MW'(ey_q);
      end
      ST_CH2: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MW-THR_W){1'b0}}, thr_q});
        mul_b  = $signed({{(MW-THR_W){1'b0}}, thr_q});
      end
      ST_CH3: begin
        mul_en = 1'b1;
        mul_a  = mul_p[MW-1:0];
        mul_b  = $signed(chord_q);
      end
      ST_CH4: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MW-CW){1'b0}}, cmax_q});
        mul_b  = $signed({{(MW-CW){1'b0}}, cmax_q});
      end
      default: ;
    endcase
  end

  // memory addresses and write strobes
  always_comb begin
    store_raddr = i_q;
    case (state_q)
      ST_SEG:    store_raddr = seg_s;
      ST_RD_E:   store_raddr = e_q;
      ST_OUT_RD: store_raddr = out_idx_q;
      default:   store_raddr = i_q;
    endcase
    store_we    = in_acc && (count_q < DW'(MAX_POINTS));
    stack_raddr = IDXW'(depth_q - DW'(1));
    stack_we    = 1'b0;
    stack_waddr = IDXW'(depth_q);
    stack_wdata = {s_q, best_q};
    case (state_q)
      ST_INIT: begin
        stack_we    = (count_q >= DW'(3));
        stack_waddr = '0;
        stack_wdata = {{IDXW{1'b0}}, IDXW'(count_q - DW'(1))};
      end
      ST_CH5: begin
        stack_we    = (lhs >= rhs_ext) &&
                      (({1'b0, depth_q} + (DW+1)'(2)) <= (DW+1)'(MAX_POINTS));
        stack_waddr = IDXW'(depth_q);
        stack_wdata = {s_q, best_q};
      end
      ST_PUSH2: begin
        stack_we    = 1'b1;
        stack_waddr = IDXW'(depth_q + DW'(1));
        stack_wdata = {best_q, e_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[IDXW'(count_q)] <= s_axis_tdata_i[2*C-1:0];
    end
    store_rdata_q <= store_mem[store_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      spc_q <= SPC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_THRESHOLD: thr_q <= cfg_wdata_i;
        CFG_SPACING:   spc_q <= cfg_wdata_i[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      keep_q      <= '1;
      count_q     <= '0;
      depth_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (count_q < DW'(MAX_POINTS)) begin
              keep_q[IDXW'(count_q)] <= 1'b1;
              count_q <= count_q + DW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (s_axis_tlast_i) state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          out_idx_q <= '0;
          if (count_q >= DW'(3)) begin
            depth_q <= DW'(1);
            state_q <= ST_POP;
          end else begin
            state_q <= ST_OUT_RD;
          end
        end
        ST_POP: begin
          if (depth_q == '0) begin
            out_idx_q <= '0;
            state_q   <= ST_OUT_RD;
          end else begin
            depth_q <= depth_q - DW'(1);
            state_q <= ST_SEG;
          end
        end
        ST_SEG: begin
          s_q <= seg_s;
          e_q <= seg_e;
          state_q <= (seg_e <= seg_s) ? ST_POP : ST_RD_E;
        end
        ST_RD_E: begin
          xs_q <= rd_x;
          ys_q <= rd_y;
          state_q <= ST_ENDS;
        end
        ST_ENDS: begin
          ex_q   <= $signed({1'b0, rd_x}) - $signed({1'b0, xs_q});
          ey_q   <= $signed({1'b0, rd_y}) - $signed({1'b0, ys_q});
          i_q    <= s_q + IDXW'(1);
          cmax_q <= '0;
          best_q <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (i_q == e_q) begin
            state_q <= ST_DECIDE;
          end else if (keep_q[i_q]) begin
            state_q <= ST_PT;
          end else begin
            i_q <= i_q + IDXW'(1);
          end
        end
        ST_PT: begin
          px_q <= $signed({1'b0, rd_x}) - $signed({1'b0, xs_q});
          py_q <= $signed({1'b0, rd_y}) - $signed({1'b0, ys_q});
          state_q <= ST_M1;
        end
        ST_M1: state_q <= ST_M2;
        ST_M2: begin
          prod1_q <= mul_p;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          // first point of strictly greater distance wins
          if (cross_c > cmax_q) begin
            cmax_q <= cross_c;
            best_q <= i_q;
          end
          i_q <= i_q + IDXW'(1);
          state_q <= ST_SCAN;
        end
        ST_DECIDE: begin
          if (cmax_q == '0) begin
            line_q  <= 1'b1;
            i_q     <= s_q;
            phase_q <= '0;
            state_q <= ST_SWEEP;
          end else begin
            state_q <= ST_CH1;
          end
        end
        ST_CH1: begin
          acc_q   <= mul_p[MW-1:0];
          state_q <= ST_CH2;
        end
        ST_CH2: begin
          chord_q <= acc_q + mul_p[MW-1:0];
          state_q <= ST_CH3;
        end
        ST_CH3: state_q <= ST_CH4;
        ST_CH4: begin
          rhs_q   <= mul_p;
          state_q <= ST_CH5;
        end
        ST_CH5: begin
          if (stack_we) begin
            state_q <= ST_PUSH2;
          end else begin
            line_q  <= 1'b0;
            i_q     <= s_q;
            phase_q <= '0;
            state_q <= ST_SWEEP;
          end
        end
        ST_PUSH2: begin
          depth_q <= depth_q + DW'(2);
          state_q <= ST_POP;
        end
        ST_SWEEP: begin
          if (i_q == e_q) begin
            if (line_q) keep_q[i_q] <= 1'b1;
            state_q <= ST_POP;
          end else begin
            if (i_q != s_q) begin
              keep_q[i_q] <= line_q && (phase_q == '0) && i_before_last;
            end else if (line_q && i_before_last) begin
              keep_q[i_q] <= 1'b1;
            end
            phase_q <= (phase_q == spacing - SPC_W'(1)) ? '0 : phase_q + SPC_W'(1);
            i_q <= i_q + IDXW'(1);
          end
        end
        ST_OUT_RD: state_q <= ST_OUT_LD;
        ST_OUT_LD: begin
          out_data_q  <= OUT_W'({ovf_q, keep_q[out_idx_q], rd_y, rd_x, out_idx_q});
          out_last_q  <= (DW'(out_idx_q) + DW'(1)) == count_q;
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT_HOLD;
        end
        ST_OUT_HOLD: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            out_last_q  <= 1'b0;
            if (out_last_q) begin
              // contour done: return to reset state
              keep_q  <= '1;
              count_q <= '0;
              depth_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              out_idx_q <= out_idx_q + IDXW'(1);
              state_q   <= ST_OUT_RD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while a result is pending");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_POINTS))
    else $error("segment stack overrun");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      ((DW'(out_idx_q) + DW'(1)) == count_q))
    else $error("last result not at final point");
`endif

endmodule
